@@ rtl/core/rcnr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnr_pkg
// Shared types and constants of the reference-counted name registry.
// ----------------------------------------------------------------------------
package rcnr_pkg;

  localparam int SLOTS      = 3;
  localparam int SLOT_W     = 2;    // width of the slot_sel / slot_out fields
  localparam int NAME_MAX   = 255;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int LEN_W      = 8;
  localparam int CHAR_W     = 8;
  localparam int COUNT_OUT_W = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'h20;

  typedef enum logic [1:0] {
    CMD_ACQ      = 2'd0,
    CMD_REL_NAME = 2'd1,
    CMD_REL_SLOT = 2'd2,
    CMD_REL_KEY  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_CREATED     = 3'd1,
    ST_FULL        = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_DECREMENTED = 3'd4,
    ST_REMOVED     = 3'd5,
    ST_EMPTY       = 3'd6,
    ST_SATURATED   = 3'd7
  } status_t;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Name hasher view of the current byte: key if the name ended here.
  typedef struct packed {
    key_t key;
    logic empty;
  } name_res_t;

endpackage

@@ rtl/core/rcnr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnr_in_if / rcnr_out_if
// Valid/ready channels of the name registry: request in, result out.
// ----------------------------------------------------------------------------
interface rcnr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  name_char;
  logic        last_char;
  logic [1:0]  slot_sel;
  logic [31:0] key_in;

  modport source (output valid, output cmd, output name_char, output last_char,
                  output slot_sel, output key_in, input ready);
  modport sink   (input valid, input cmd, input name_char, input last_char,
                  input slot_sel, input key_in, output ready);
endinterface

interface rcnr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  slot_out;
  logic [31:0] key_out;
  logic [15:0] count_out;
  logic        all_empty;

  modport source (output valid, output status, output slot_out, output key_out,
                  output count_out, output all_empty, input ready);
  modport sink   (input valid, input status, input slot_out, input key_out,
                  input count_out, input all_empty, output ready);
endinterface

@@ rtl/core/rcnr_name.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnr_name
// Name hasher: folds, filters and accumulates name bytes into a 32-bit key.
// ----------------------------------------------------------------------------
module rcnr_name (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic                              last,
  input  logic [rcnr_pkg::CHAR_W-1:0]       ch,
  output rcnr_pkg::name_res_t               res
);

  rcnr_pkg::key_t                hash_r,  hash_nxt;
  logic [rcnr_pkg::LEN_W-1:0]    kept_r,  kept_nxt;
  logic [1:0]                    phase_r, phase_nxt;
  logic [rcnr_pkg::LEN_W-1:0]    raw_r,   raw_nxt;
  logic                          ended_r, ended_nxt;

  logic                          active;
  logic                          keep;
  logic [rcnr_pkg::CHAR_W-1:0]   cu;
  rcnr_pkg::key_t                shifted;

  always_comb begin
    active = !ended_r && (raw_r < rcnr_pkg::LEN_W'(rcnr_pkg::NAME_MAX));
    keep   = active && (ch != rcnr_pkg::CH_NUL) && (ch != rcnr_pkg::CH_SLASH) &&
             (ch != rcnr_pkg::CH_BSLASH);
    cu     = ch;
    if (ch >= rcnr_pkg::CH_LOWER_A && ch <= rcnr_pkg::CH_LOWER_Z) begin
      cu = ch - rcnr_pkg::CASE_FOLD;
    end
    case (phase_r)
      2'd0:    shifted = {cu, 24'b0};
      2'd1:    shifted = {8'b0, cu, 16'b0};
      2'd2:    shifted = {16'b0, cu, 8'b0};
      default: shifted = '0;
    endcase

    hash_nxt  = keep ? hash_r + shifted : hash_r;
    kept_nxt  = keep ? kept_r + 1'b1 : kept_r;
    phase_nxt = keep ? ((phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1) : phase_r;
    raw_nxt   = active ? raw_r + 1'b1 : raw_r;
    ended_nxt = ended_r || (active && ch == rcnr_pkg::CH_NUL);

    res.key   = hash_nxt + {{(rcnr_pkg::KEY_W - rcnr_pkg::LEN_W){1'b0}}, kept_nxt};
    res.empty = (kept_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= '0;
      kept_r  <= '0;
      phase_r <= '0;
      raw_r   <= '0;
      ended_r <= 1'b0;
    end else if (step) begin
      if (last) begin
        hash_r  <= '0;
        kept_r  <= '0;
        phase_r <= '0;
        raw_r   <= '0;
        ended_r <= 1'b0;
      end else begin
        hash_r  <= hash_nxt;
        kept_r  <= kept_nxt;
        phase_r <= phase_nxt;
        raw_r   <= raw_nxt;
        ended_r <= ended_nxt;
      end
    end
  end

endmodule

@@ rtl/core/refcounted_name_registry.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_name_registry
// Three-slot reference-counted registry keyed by a streamed name hash.
// ----------------------------------------------------------------------------
// Throughput is one transaction per clock: each request byte is taken into an
// input register, from which a single pass of logic hashes the byte, does
// the parallel three-slot key match, updates the slot table and loads the
// result register, so the result of a completing byte goes from the input
// register straight to the result register. The rate is set by that slot
// lookup-and-update, which lets every request see the table left by the one
// before it. Name bytes (cmd 0 acquire, cmd 1 release) return nothing until
// the byte flagged last_char; release by slot (cmd 2) and by key (cmd 3)
// always return one result and do not disturb a name being received. The
// input keeps accepting while a finished result waits on out_ch; it stalls
// only when a result-producing request meets a full, stalled result register.
// ----------------------------------------------------------------------------
module refcounted_name_registry (
  input  logic           clk,
  input  logic           rst_n,
  rcnr_in_if.sink        in_ch,
  rcnr_out_if.source     out_ch
);

  localparam int SW = rcnr_pkg::SLOT_W;

  // input register
  logic                          vld_r;
  rcnr_pkg::cmd_t                cmd_r;
  logic [rcnr_pkg::CHAR_W-1:0]   char_r;
  logic                          last_r;
  logic [SW-1:0]                 sel_r;
  rcnr_pkg::key_t                key_in_r;

  // slot table
  rcnr_pkg::key_t                keys_r   [rcnr_pkg::SLOTS];
  rcnr_pkg::count_t              counts_r [rcnr_pkg::SLOTS];
  rcnr_pkg::key_t                keys_nxt   [rcnr_pkg::SLOTS];
  rcnr_pkg::count_t              counts_nxt [rcnr_pkg::SLOTS];

  // result register
  logic                          ovld_r;
  rcnr_pkg::status_t             status_r;
  logic [SW-1:0]                 slot_r;
  rcnr_pkg::key_t                key_out_r;
  rcnr_pkg::count_t              count_r;
  logic                          empty_r;

  rcnr_pkg::name_res_t           name_res;
  logic                          is_name;
  logic                          produces;
  logic                          go;
  logic                          load;
  logic                          out_rdy;

  rcnr_pkg::status_t             status_c;
  logic [SW-1:0]                 slot_c;
  rcnr_pkg::key_t                key_c;
  rcnr_pkg::count_t              count_c;
  logic                          empty_c;

  rcnr_pkg::key_t                look_key;
  logic                          hit_any, free_any, sel_ok;
  logic [SW-1:0]                 hit_idx, free_idx;
  rcnr_pkg::count_t              hit_cnt, sel_cnt;
  rcnr_pkg::key_t                sel_key;
  logic                          do_rel;
  logic [SW-1:0]                 rel_idx;
  rcnr_pkg::key_t                rel_key;
  rcnr_pkg::count_t              rel_cnt, rel_dec;

  assign out_rdy  = out_ch.ready;
  assign is_name  = (cmd_r == rcnr_pkg::CMD_ACQ) || (cmd_r == rcnr_pkg::CMD_REL_NAME);
  assign produces = !is_name || last_r;
  assign go       = vld_r && (!produces || !ovld_r || out_rdy);
  assign load     = go && produces;
  assign in_ch.ready = !vld_r || go;

  rcnr_name u_name (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (go && is_name),
    .last  (last_r),
    .ch    (char_r),
    .res   (name_res)
  );

  // Slot lookup, request decode and table update.
  always_comb begin
    look_key = (cmd_r == rcnr_pkg::CMD_REL_KEY) ? key_in_r : name_res.key;

    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    sel_ok   = 1'b0;
    sel_key  = '0;
    for (int i = rcnr_pkg::SLOTS - 1; i >= 0; i--) begin
      if (look_key != '0 && keys_r[i] == look_key) begin
        hit_any = 1'b1;
        hit_idx = SW'(i);
      end
      if (keys_r[i] == '0) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
      if (sel_r == SW'(i) && keys_r[i] != '0) begin
        sel_ok  = 1'b1;
        sel_key = keys_r[i];
      end
    end

    hit_cnt = '0;
    sel_cnt = '0;
    for (int i = 0; i < rcnr_pkg::SLOTS; i++) begin
      if (hit_idx == SW'(i)) hit_cnt = counts_r[i];
      if (sel_r == SW'(i))   sel_cnt = counts_r[i];
    end

    status_c = rcnr_pkg::ST_NOT_FOUND;
    slot_c   = '0;
    key_c    = look_key;
    count_c  = '0;
    do_rel   = 1'b0;
    rel_idx  = hit_idx;
    rel_key  = look_key;
    rel_cnt  = hit_cnt;
    for (int i = 0; i < rcnr_pkg::SLOTS; i++) begin
      keys_nxt[i]   = keys_r[i];
      counts_nxt[i] = counts_r[i];
    end

    case (cmd_r)
      rcnr_pkg::CMD_REL_SLOT: begin
        key_c = '0;
        if (sel_ok) begin
          do_rel  = 1'b1;
          rel_idx = sel_r;
          rel_key = sel_key;
          rel_cnt = sel_cnt;
        end
      end
      rcnr_pkg::CMD_REL_KEY: begin
        do_rel = hit_any;
      end
      rcnr_pkg::CMD_REL_NAME: begin
        if (name_res.empty) begin
          status_c = rcnr_pkg::ST_EMPTY;
          key_c    = '0;
        end else begin
          do_rel = hit_any;
        end
      end
      rcnr_pkg::CMD_ACQ: begin
        if (name_res.empty) begin
          status_c = rcnr_pkg::ST_EMPTY;
          key_c    = '0;
        end else if (look_key == '0) begin
          status_c = rcnr_pkg::ST_FULL;
        end else if (hit_any) begin
          slot_c = hit_idx;
          if (hit_cnt == rcnr_pkg::COUNT_TOP) begin
            status_c = rcnr_pkg::ST_SATURATED;
            count_c  = hit_cnt;
          end else begin
            status_c = rcnr_pkg::ST_FOUND;
            count_c  = hit_cnt + 1'b1;
            for (int i = 0; i < rcnr_pkg::SLOTS; i++) begin
              if (hit_idx == SW'(i)) counts_nxt[i] = count_c;
            end
          end
        end else if (free_any) begin
          status_c = rcnr_pkg::ST_CREATED;
          slot_c   = free_idx;
          count_c  = rcnr_pkg::count_t'(1);
          for (int i = 0; i < rcnr_pkg::SLOTS; i++) begin
            if (free_idx == SW'(i)) begin
              keys_nxt[i]   = look_key;
              counts_nxt[i] = count_c;
            end
          end
        end else begin
          status_c = rcnr_pkg::ST_FULL;
        end
      end
      default: begin
        status_c = rcnr_pkg::ST_NOT_FOUND;
      end
    endcase

    // shared decrement path for all three release forms
    rel_dec = (rel_cnt == '0) ? '0 : rel_cnt - 1'b1;
    if (do_rel) begin
      slot_c  = rel_idx;
      key_c   = rel_key;
      count_c = rel_dec;
      status_c = (rel_dec == '0) ? rcnr_pkg::ST_REMOVED : rcnr_pkg::ST_DECREMENTED;
      for (int i = 0; i < rcnr_pkg::SLOTS; i++) begin
        if (rel_idx == SW'(i)) begin
          counts_nxt[i] = rel_dec;
          if (rel_dec == '0) keys_nxt[i] = '0;
        end
      end
    end

    empty_c = 1'b1;
    for (int i = 0; i < rcnr_pkg::SLOTS; i++) begin
      if (keys_nxt[i] != '0) empty_c = 1'b0;
    end
  end

  // input register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      cmd_r    <= rcnr_pkg::cmd_t'(in_ch.cmd);
      char_r   <= in_ch.name_char;
      last_r   <= in_ch.last_char;
      sel_r    <= in_ch.slot_sel;
      key_in_r <= in_ch.key_in;
    end
  end

  // slot table: only a completed request touches it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rcnr_pkg::SLOTS; i++) begin
        keys_r[i]   <= '0;
        counts_r[i] <= '0;
      end
    end else if (load) begin
      for (int i = 0; i < rcnr_pkg::SLOTS; i++) begin
        keys_r[i]   <= keys_nxt[i];
        counts_r[i] <= counts_nxt[i];
      end
    end
  end

  // result register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (load) begin
      ovld_r <= 1'b1;
    end else if (out_rdy) begin
      ovld_r <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (load) begin
      status_r  <= status_c;
      slot_r    <= slot_c;
      key_out_r <= key_c;
      count_r   <= count_c;
      empty_r   <= empty_c;
    end
  end

  assign out_ch.valid     = ovld_r;
  assign out_ch.status    = status_r;
  assign out_ch.slot_out  = slot_r;
  assign out_ch.key_out   = key_out_r;
  assign out_ch.count_out = rcnr_pkg::COUNT_OUT_W'(count_r);
  assign out_ch.all_empty = empty_r;

`ifndef SYNTH
  // a newly created slot always reports a count of one
  a_created_one: assert property (@(posedge clk) disable iff (!rst_n)
    load && status_c == rcnr_pkg::ST_CREATED |=> count_r == rcnr_pkg::count_t'(1))
    else $error("created slot did not report count one");

  // a stalled request stays parked in the input register
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !go |=> vld_r && $stable(cmd_r) && $stable(last_r))
    else $error("stalled request lost from input register");

  // a partial name byte never produces a result
  a_partial_silent: assert property (@(posedge clk) disable iff (!rst_n)
    go && !produces |=> ovld_r == ($past(ovld_r) && !$past(out_rdy)))
    else $error("partial name byte changed result valid");

  // an empty table cannot follow a hit, a creation or a decrement
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && empty_r |-> status_r != rcnr_pkg::ST_FOUND &&
      status_r != rcnr_pkg::ST_CREATED && status_r != rcnr_pkg::ST_DECREMENTED &&
      status_r != rcnr_pkg::ST_SATURATED)
    else $error("all_empty set with a live slot status");
`endif

endmodule

@@ test/tb_refcounted_name_registry.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_name_registry
// Self-checking bench for the reference-counted name registry.
// ----------------------------------------------------------------------------
// A table of directed requests covers the reset state, empty names, zero
// bytes, a full table, and releases that arrive between name bytes. Random
// name traffic follows, drawn mostly from a small pool of names so that the
// slots fill, match and drain. A final pass releases every slot down to an
// empty table. Results are checked field by field against pinned values or
// an in-bench model of the slot table and the name hash.
// ----------------------------------------------------------------------------
module tb_refcounted_name_registry;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 780;
  localparam int IDLE_PCT     = 21;      // chance per cycle that a side idles
  localparam int DRAIN_CYCLES = 16;      // settling margin before the final report
  localparam int POOL_SIZE    = 6;
  localparam int NO_NUL       = -1;

  localparam logic [rcnr_pkg::CHAR_W-1:0] CH_UPPER_A = 8'h41;

  // Keys of one-letter names: letter << 24 plus a kept length of one.
  localparam rcnr_pkg::key_t KEY_A = 32'h4100_0001;
  localparam rcnr_pkg::key_t KEY_Q = 32'h5100_0001;
  localparam rcnr_pkg::key_t KEY_Z = 32'h5a00_0001;

  typedef logic [rcnr_pkg::CHAR_W-1:0] byte_q_t[$];

  typedef struct packed {
    rcnr_pkg::cmd_t                  cmd;
    logic [rcnr_pkg::CHAR_W-1:0]     ch;
    logic                            last;
    logic [rcnr_pkg::SLOT_W-1:0]     sel;
    rcnr_pkg::key_t                  key;
  } req_t;

  typedef struct packed {
    rcnr_pkg::status_t                status;
    logic [rcnr_pkg::SLOT_W-1:0]      slot;
    rcnr_pkg::key_t                   key;
    logic [rcnr_pkg::COUNT_OUT_W-1:0] count;
    logic                             all_empty;
  } result_t;

  // Typed-in expectation riding along with a transaction, in send order.
  typedef struct packed {
    logic    pinned;
    result_t want;
  } pin_t;

  typedef struct {
    rcnr_pkg::cmd_t              cmd;
    string                       text;
    int                          nul_at;     // byte replaced by a zero, NO_NUL for none
    bit                          keep_open;  // no last_char: name stays in progress
    logic [rcnr_pkg::SLOT_W-1:0] sel;
    rcnr_pkg::key_t              key;
    bit                          pinned;
    result_t                     want;
  } row_t;

  logic clk;
  logic rst_n;

  rcnr_in_if  in_ch ();
  rcnr_out_if out_ch ();

  refcounted_name_registry u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Registry model state: slot table plus the name being hashed.
  // --------------------------------------------------------------------------
  rcnr_pkg::key_t              slot_key_q [rcnr_pkg::SLOTS] = '{default: '0};
  rcnr_pkg::count_t            slot_cnt_q [rcnr_pkg::SLOTS] = '{default: '0};
  rcnr_pkg::key_t              hash_acc   = '0;
  logic [rcnr_pkg::LEN_W-1:0]  kept_len   = '0;
  int                          byte_phase = 0;
  int                          raw_len    = 0;
  bit                          name_stop  = 1'b0;   // a zero byte ended the name

  result_t expected_results[$];
  pin_t    pin_q[$];
  row_t    plan[$];

  int  mismatch_count  = 0;
  int  accepted_items  = 0;
  int  checked_results = 0;
  int  sent_items      = 0;
  int  cycle_count     = 0;
  bit  calm_run        = 1'b0;   // suppresses idling on both sides

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result record as the block would report it; all_empty from the table.
  function automatic result_t pack_result(input rcnr_pkg::status_t st, input int slot,
                                          input rcnr_pkg::key_t k,
                                          input rcnr_pkg::count_t cnt);
    result_t res;
    res.status    = st;
    res.slot      = slot[rcnr_pkg::SLOT_W-1:0];
    res.key       = k;
    res.count     = cnt;
    res.all_empty = 1'b1;
    for (int i = 0; i < rcnr_pkg::SLOTS; i++)
      if (slot_key_q[i] != '0) res.all_empty = 1'b0;
    return res;
  endfunction

  function automatic result_t want_of(input rcnr_pkg::status_t st, input int slot,
                                      input rcnr_pkg::key_t k, input int cnt,
                                      input bit ae);
    result_t res;
    res = '{status: st, slot: slot[rcnr_pkg::SLOT_W-1:0], key: k,
            count: cnt[rcnr_pkg::COUNT_OUT_W-1:0], all_empty: ae};
    return res;
  endfunction

  // Key 0 marks a free slot and never matches.
  function automatic int find_slot(input rcnr_pkg::key_t k);
    if (k == '0) return -1;
    for (int i = 0; i < rcnr_pkg::SLOTS; i++)
      if (slot_key_q[i] == k) return i;
    return -1;
  endfunction

  function automatic result_t drop_ref(input int i, input rcnr_pkg::key_t k);
    if (slot_cnt_q[i] != '0) slot_cnt_q[i]--;
    if (slot_cnt_q[i] == '0) begin
      slot_key_q[i] = '0;
      return pack_result(rcnr_pkg::ST_REMOVED, i, k, '0);
    end
    return pack_result(rcnr_pkg::ST_DECREMENTED, i, k, slot_cnt_q[i]);
  endfunction

  // Advances the model by one accepted transaction; returns 1 when the
  // transaction completes a request and so produces a result.
  function automatic bit predict_request(input req_t r, output result_t res);
    rcnr_pkg::key_t              k;
    logic [rcnr_pkg::CHAR_W-1:0] c;
    bit                          no_name;
    int                          hit;
    int                          free_slot;
    res = '0;
    k   = '0;
    if (r.cmd == rcnr_pkg::CMD_REL_SLOT) begin
      if (r.sel < rcnr_pkg::SLOTS && slot_key_q[r.sel] != '0)
        res = drop_ref(int'(r.sel), slot_key_q[r.sel]);
      else
        res = pack_result(rcnr_pkg::ST_NOT_FOUND, 0, '0, '0);
      return 1'b1;
    end
    if (r.cmd == rcnr_pkg::CMD_REL_KEY) begin
      k = r.key;
    end else begin
      // Name byte: only the first NAME_MAX raw bytes count, a zero ends it.
      if (!name_stop && raw_len < rcnr_pkg::NAME_MAX) begin
        raw_len++;
        c = r.ch;
        if (c == rcnr_pkg::CH_NUL) begin
          name_stop = 1'b1;
        end else if (c != rcnr_pkg::CH_SLASH && c != rcnr_pkg::CH_BSLASH) begin
          if (c >= rcnr_pkg::CH_LOWER_A && c <= rcnr_pkg::CH_LOWER_Z)
            c = c - rcnr_pkg::CASE_FOLD;
          hash_acc   = hash_acc + (rcnr_pkg::key_t'(c) << (24 - 8 * byte_phase));
          byte_phase = (byte_phase >= 2) ? 0 : byte_phase + 1;
          kept_len   = kept_len + 1'b1;
        end
      end
      if (!r.last) return 1'b0;
      no_name    = (kept_len == '0);
      k          = hash_acc + rcnr_pkg::key_t'(kept_len);
      hash_acc   = '0;
      kept_len   = '0;
      byte_phase = 0;
      raw_len    = 0;
      name_stop  = 1'b0;
      if (no_name) begin
        res = pack_result(rcnr_pkg::ST_EMPTY, 0, '0, '0);
        return 1'b1;
      end
      if (r.cmd == rcnr_pkg::CMD_ACQ) begin
        hit = find_slot(k);
        if (k == '0) begin
          res = pack_result(rcnr_pkg::ST_FULL, 0, k, '0);
        end else if (hit >= 0) begin
          if (slot_cnt_q[hit] == rcnr_pkg::COUNT_TOP) begin
            res = pack_result(rcnr_pkg::ST_SATURATED, hit, k, slot_cnt_q[hit]);
          end else begin
            slot_cnt_q[hit]++;
            res = pack_result(rcnr_pkg::ST_FOUND, hit, k, slot_cnt_q[hit]);
          end
        end else begin
          free_slot = -1;
          for (int i = 0; i < rcnr_pkg::SLOTS; i++)
            if (free_slot < 0 && slot_key_q[i] == '0) free_slot = i;
          if (free_slot < 0) begin
            res = pack_result(rcnr_pkg::ST_FULL, 0, k, '0);
          end else begin
            slot_key_q[free_slot] = k;
            slot_cnt_q[free_slot] = rcnr_pkg::count_t'(1);
            res = pack_result(rcnr_pkg::ST_CREATED, free_slot, k, rcnr_pkg::count_t'(1));
          end
        end
        return 1'b1;
      end
    end
    // Release by key, or by a name that has just been hashed.
    hit = find_slot(k);
    res = (hit < 0) ? pack_result(rcnr_pkg::ST_NOT_FOUND, 0, k, '0) : drop_ref(hit, k);
    return 1'b1;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: both handshakes are sampled at the same edge. The request
  // side is handled first so a result can never outrun its expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    req_t    seen;
    result_t predicted;
    result_t got;
    result_t want;
    pin_t    pin;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen = '{cmd: rcnr_pkg::cmd_t'(in_ch.cmd), ch: in_ch.name_char,
                 last: in_ch.last_char, sel: in_ch.slot_sel, key: in_ch.key_in};
        pin  = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        accepted_items++;
        if (predict_request(seen, predicted))
          expected_results.push_back(pin.pinned ? pin.want : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{status: rcnr_pkg::status_t'(out_ch.status), slot: out_ch.slot_out,
                key: out_ch.key_out, count: out_ch.count_out,
                all_empty: out_ch.all_empty};
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: status %0d key 0x%0h",
                 got.status, got.key);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status",    32'(want.status),    32'(got.status));
          check_field("slot_out",  32'(want.slot),      32'(got.slot));
          check_field("key_out",   want.key,            got.key);
          check_field("count_out", 32'(want.count),     32'(got.count));
          check_field("all_empty", 32'(want.all_empty), 32'(got.all_empty));
          checked_results++;
        end
      end
    end
  end

  // Result sink: random backpressure unless a calm stretch is running.
  always @(posedge clk) begin
    out_ch.ready <= calm_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Random filler for fields the command does not use; keeps every input bit
  // toggling.
  function automatic req_t noise_req();
    req_t r;
    r.cmd  = rcnr_pkg::cmd_t'($urandom_range(0, 3));
    r.ch   = rcnr_pkg::CHAR_W'($urandom_range(0, 255));
    r.last = 1'($urandom_range(0, 1));
    r.sel  = rcnr_pkg::SLOT_W'($urandom_range(0, 3));
    r.key  = $urandom();
    return r;
  endfunction

  function automatic logic [rcnr_pkg::CHAR_W-1:0] any_letter();
    return rcnr_pkg::CHAR_W'((CH_UPPER_A + $urandom_range(0, 25)) |
                             ($urandom_range(0, 1) ? rcnr_pkg::CASE_FOLD : 8'h00));
  endfunction

  // One transaction: optional idle cycles, then hold valid until accepted.
  task automatic send_item(input req_t r, input bit pinned, input result_t want);
    while (!calm_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pin_q.push_back('{pinned: pinned, want: want});
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= r.cmd;
    in_ch.name_char <= r.ch;
    in_ch.last_char <= r.last;
    in_ch.slot_sel  <= r.sel;
    in_ch.key_in    <= r.key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic random_release();
    req_t r;
    int   pick;
    r = noise_req();
    if ($urandom_range(0, 1)) begin
      r.cmd = rcnr_pkg::CMD_REL_SLOT;
    end else begin
      r.cmd = rcnr_pkg::CMD_REL_KEY;
      pick  = $urandom_range(0, 9);
      if (pick < 6)
        r.key = slot_key_q[rcnr_pkg::SLOT_W'($urandom_range(0, rcnr_pkg::SLOTS - 1))];
      else if (pick == 6)
        r.key = '0;
    end
    send_item(r, 1'b0, '0);
  endtask

  // Streams a name. With mixed set, bytes before the last carry a random
  // name command and may be interleaved with slot/key releases.
  task automatic send_name(input byte_q_t bytes, input rcnr_pkg::cmd_t last_cmd,
                           input bit mixed, input bit keep_open, input bit pinned,
                           input result_t want);
    req_t r;
    bit   final_byte;
    for (int j = 0; j < bytes.size(); j++) begin
      final_byte = (j == bytes.size() - 1);
      r      = noise_req();
      r.ch   = bytes[j];
      r.last = final_byte && !keep_open;
      r.cmd  = (final_byte || !mixed) ? last_cmd : rcnr_pkg::cmd_t'($urandom_range(0, 1));
      send_item(r, pinned && r.last, want);
      if (mixed && !final_byte && $urandom_range(0, 99) < 15) random_release();
    end
  endtask

  // Lowers valid and waits until every result in flight has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0 || pin_q.size() != 0);
  endtask

  task automatic add_row(input rcnr_pkg::cmd_t c, input string text, input int nul_at,
                         input bit keep_open, input logic [rcnr_pkg::SLOT_W-1:0] sel,
                         input rcnr_pkg::key_t k, input bit pinned, input result_t want);
    plan.push_back('{c, text, nul_at, keep_open, sel, k, pinned, want});
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    byte_q_t name_pool [POOL_SIZE];
    byte_q_t pool_name;
    byte_q_t bytes;
    req_t    r;
    int      pick;
    int      seq_idx;
    int      start_items;
    int      len;
    int      n;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= rcnr_pkg::CMD_ACQ;
    in_ch.name_char <= '0;
    in_ch.last_char <= 1'b0;
    in_ch.slot_sel  <= '0;
    in_ch.key_in    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Pinned rows carry a hand-written result; the rest are
    // left to the model.
    // Empty table: every release misses, key extremes included.
    add_row(rcnr_pkg::CMD_REL_SLOT, "", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_NOT_FOUND, 0, '0, 0, 1));
    add_row(rcnr_pkg::CMD_REL_SLOT, "", NO_NUL, 0, 2'd3, '0, 1,
            want_of(rcnr_pkg::ST_NOT_FOUND, 0, '0, 0, 1));
    add_row(rcnr_pkg::CMD_REL_KEY, "", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_NOT_FOUND, 0, '0, 0, 1));
    add_row(rcnr_pkg::CMD_REL_KEY, "", NO_NUL, 0, 2'd0, '1, 1,
            want_of(rcnr_pkg::ST_NOT_FOUND, 0, '1, 0, 1));
    // Empty names: only separators, a leading zero byte, release of nothing.
    add_row(rcnr_pkg::CMD_ACQ, "/\\", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_EMPTY, 0, '0, 0, 1));
    add_row(rcnr_pkg::CMD_ACQ, "AB", 0, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_EMPTY, 0, '0, 0, 1));
    add_row(rcnr_pkg::CMD_REL_NAME, "\\", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_EMPTY, 0, '0, 0, 1));
    // Fill all three slots; case folding makes "a" and "A" one name.
    add_row(rcnr_pkg::CMD_ACQ, "a", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_CREATED, 0, KEY_A, 1, 0));
    add_row(rcnr_pkg::CMD_ACQ, "A", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_FOUND, 0, KEY_A, 2, 0));
    add_row(rcnr_pkg::CMD_ACQ, "abc/de", NO_NUL, 0, 2'd0, '0, 0, '0);
    add_row(rcnr_pkg::CMD_ACQ, "\377\377\377\377", NO_NUL, 0, 2'd0, '0, 0, '0);
    // Table full; the zero byte cuts "zz" down to "Z".
    add_row(rcnr_pkg::CMD_ACQ, "zz", 1, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_FULL, 0, KEY_Z, 0, 0));
    // Decrement, then remove, then reuse the first free slot.
    add_row(rcnr_pkg::CMD_REL_NAME, "a", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_DECREMENTED, 0, KEY_A, 1, 0));
    add_row(rcnr_pkg::CMD_REL_KEY, "", NO_NUL, 0, 2'd0, KEY_A, 1,
            want_of(rcnr_pkg::ST_REMOVED, 0, KEY_A, 0, 0));
    add_row(rcnr_pkg::CMD_ACQ, "Q", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_CREATED, 0, KEY_Q, 1, 0));
    add_row(rcnr_pkg::CMD_REL_SLOT, "", NO_NUL, 0, 2'd1, '0, 0, '0);
    add_row(rcnr_pkg::CMD_REL_SLOT, "", NO_NUL, 0, 2'd2, '0, 0, '0);
    add_row(rcnr_pkg::CMD_REL_NAME, "q", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_REMOVED, 0, KEY_Q, 0, 1));
    // Release between name bytes; the final byte's command decides.
    add_row(rcnr_pkg::CMD_ACQ, "x", NO_NUL, 1, 2'd0, '0, 0, '0);
    add_row(rcnr_pkg::CMD_REL_SLOT, "", NO_NUL, 0, 2'd0, '0, 1,
            want_of(rcnr_pkg::ST_NOT_FOUND, 0, '0, 0, 1));
    add_row(rcnr_pkg::CMD_REL_NAME, "b", NO_NUL, 0, 2'd0, '0, 0, '0);
    add_row(rcnr_pkg::CMD_ACQ, "Ab/\\c", NO_NUL, 0, 2'd0, '0, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].cmd == rcnr_pkg::CMD_REL_SLOT || plan[i].cmd == rcnr_pkg::CMD_REL_KEY) begin
        r     = noise_req();
        r.cmd = plan[i].cmd;
        r.sel = plan[i].sel;
        r.key = plan[i].key;
        send_item(r, plan[i].pinned, plan[i].want);
      end else begin
        bytes = {};
        for (int j = 0; j < plan[i].text.len(); j++)
          bytes.push_back((j == plan[i].nul_at) ? rcnr_pkg::CH_NUL : plan[i].text[j]);
        send_name(bytes, plan[i].cmd, 1'b0, plan[i].keep_open, plan[i].pinned,
                  plan[i].want);
      end
    end

    // Sender holds off until the block has answered everything.
    wait_drained();

    // Name pool: mostly letters, some separators, some arbitrary bytes.
    foreach (name_pool[p]) begin
      name_pool[p] = {};
      len = $urandom_range(1, 6);
      repeat (len) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)
          name_pool[p].push_back(any_letter());
        else if (pick == 6)
          name_pool[p].push_back($urandom_range(0, 1) ? rcnr_pkg::CH_SLASH
                                                      : rcnr_pkg::CH_BSLASH);
        else
          name_pool[p].push_back(rcnr_pkg::CHAR_W'($urandom_range(0, 255)));
      end
    end

    // Random traffic. Pool names are resent with case flips and extra
    // separators, which must hash to the same key.
    seq_idx     = 0;
    start_items = sent_items;
    while (sent_items - start_items < RANDOM_ITEMS) begin
      calm_run = (seq_idx >= 15 && seq_idx < 45);
      if (seq_idx == 50) wait_drained();
      pick = $urandom_range(0, 99);
      if (seq_idx == 3 || seq_idx == 60) begin
        // Long name, straddling the NAME_MAX cut.
        bytes = {};
        len   = $urandom_range(240, 300);
        repeat (len) bytes.push_back(any_letter());
        send_name(bytes, rcnr_pkg::cmd_t'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0, '0);
      end else if (pick < 60) begin
        bytes     = {};
        pool_name = name_pool[seq_idx % POOL_SIZE];
        foreach (pool_name[j]) begin
          if ($urandom_range(0, 9) == 0)
            bytes.push_back($urandom_range(0, 1) ? rcnr_pkg::CH_SLASH : rcnr_pkg::CH_BSLASH);
          if (pool_name[j] inside {[8'h41:8'h5a], [8'h61:8'h7a]} && $urandom_range(0, 1))
            bytes.push_back(pool_name[j] ^ rcnr_pkg::CASE_FOLD);
          else
            bytes.push_back(pool_name[j]);
        end
        send_name(bytes, ($urandom_range(0, 9) < 6) ? rcnr_pkg::CMD_ACQ
                                                    : rcnr_pkg::CMD_REL_NAME,
                  1'b1, 1'b0, 1'b0, '0);
      end else if (pick < 85) begin
        random_release();
      end else if (pick < 95) begin
        bytes = {};
        len   = $urandom_range(1, 10);
        repeat (len) bytes.push_back(rcnr_pkg::CHAR_W'($urandom_range(0, 255)));
        send_name(bytes, rcnr_pkg::cmd_t'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0, '0);
      end else begin
        // Stray name byte; last_char random, may leave a name in progress.
        r     = noise_req();
        r.cmd = rcnr_pkg::cmd_t'($urandom_range(0, 1));
        send_item(r, 1'b0, '0);
      end
      seq_idx++;
    end
    calm_run = 1'b0;

    // Close any name left open, then release every slot down to an empty
    // table. Counts are read only while nothing is in flight.
    r      = noise_req();
    r.cmd  = rcnr_pkg::CMD_ACQ;
    r.ch   = rcnr_pkg::CH_NUL;
    r.last = 1'b1;
    send_item(r, 1'b0, '0);
    wait_drained();
    for (int s = 0; s < rcnr_pkg::SLOTS; s++) begin
      n = int'(slot_cnt_q[s]);
      repeat (n) begin
        r     = noise_req();
        r.cmd = rcnr_pkg::CMD_REL_SLOT;
        r.sel = rcnr_pkg::SLOT_W'(s);
        send_item(r, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d transactions in, %0d results checked over %0d cycles.",
             accepted_items, checked_results, cycle_count);
    $display("Covered: directed corners, random pooled/long/noisy names, full drain.");
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rcnr_pkg.sv
rtl/core/rcnr_if.sv
rtl/core/rcnr_name.sv
rtl/core/refcounted_name_registry.sv
test/tb_refcounted_name_registry.sv
